// File: design/aes_block_encrypt_assert.svh
// ----------------------------------------------------------------------------
// aes block encrypt assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef AES_BLOCK_ENCRYPT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_ASSERT_SVH

// same-cycle implication
`define AES_ENC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aes_block_encrypt check failed");

// next-cycle implication
`define AES_ENC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aes_block_encrypt check failed");

`endif

// File: design/aes_enc_pkg.sv
// ----------------------------------------------------------------------------
// aes_enc_pkg
// types, constants and round functions for the aes block encrypt core
// ----------------------------------------------------------------------------
package aes_enc_pkg;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ENCRYPT = 1'b1;
  localparam logic HALF_UPPER  = 1'b0;
  localparam logic [3:0] NR_MIN = 4'd10;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_ROUND
  } aes_enc_state_t;

  typedef logic [127:0] aes_blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
    8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
    8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
    8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
    8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
    8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
    8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
    8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
    8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
    8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
    8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
    8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
    8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
    8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
    8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
    8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
    8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte 0 sits in the top bits
  function automatic logic [7:0] blk_byte(input aes_blk_t b, input int idx);
    blk_byte = b[127 - 8 * idx -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic aes_blk_t sub_shift(input aes_blk_t s);
    aes_blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[blk_byte(s, r + 4 * ((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic aes_blk_t mix_columns(input aes_blk_t s);
    aes_blk_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = blk_byte(s, 4 * c);
      a1  = blk_byte(s, 4 * c + 1);
      a2  = blk_byte(s, 4 * c + 2);
      a3  = blk_byte(s, 4 * c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8 * (4 * c)     -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127 - 8 * (4 * c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127 - 8 * (4 * c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127 - 8 * (4 * c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // one pass of the shared round unit
  function automatic aes_blk_t aes_round(input aes_blk_t s, input aes_blk_t key,
                                         input logic first, input logic final_rnd);
    aes_blk_t t;
    if (first) begin
      t = s;
    end else begin
      t = sub_shift(s);
      if (!final_rnd) begin
        t = mix_columns(t);
      end
    end
    return t ^ key;
  endfunction

endpackage

// File: design/aes_enc_in_if.sv
// ----------------------------------------------------------------------------
// aes_enc_in_if
// request channel into the aes block encrypt core
// ----------------------------------------------------------------------------
interface aes_enc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  key_index;
  logic        key_half;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  logic        last_block;

  modport source (output valid, cmd, key_index, key_half, data_hi, data_lo, last_block,
                  input ready);
  modport sink   (input valid, cmd, key_index, key_half, data_hi, data_lo, last_block,
                  output ready);
endinterface

// File: design/aes_enc_out_if.sv
// ----------------------------------------------------------------------------
// aes_enc_out_if
// ciphertext channel out of the aes block encrypt core
// ----------------------------------------------------------------------------
interface aes_enc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;
  logic        last_out;

  modport source (output valid, cipher_hi, cipher_lo, last_out, input ready);
  modport sink   (input valid, cipher_hi, cipher_lo, last_out, output ready);
endinterface

// File: design/aes_block_encrypt.sv
// ----------------------------------------------------------------------------
// aes_block_encrypt
// aes ecb encryption with externally loaded round keys, one shared round unit
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  in_chan   sink       cmd, key_index, key_half, data_hi, data_lo, last_block
//  out_chan  source     cipher_hi, cipher_lo, last_out
//  cfg_*     write      num_rounds
//
//  a key load request gives no result
//  an encrypt request is accepted in the idle state, then makes one pass of the
//  round unit per round plus the initial key add
//  in_ready is low while a block is in flight; the finished block waits in the
//  output register, and the last round holds while that register is full
//  reset clears control state and num_rounds (10); the key store is not cleared
// ----------------------------------------------------------------------------
module aes_block_encrypt #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  aes_enc_in_if.sink   in_chan,
  aes_enc_out_if.source out_chan,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata
);
  import aes_enc_pkg::*;

  localparam int KIDX_W = $clog2(MAX_ROUNDS + 1);
  localparam logic [KIDX_W-1:0] LAST_KEY = KIDX_W'(MAX_ROUNDS);

  aes_enc_state_t    state_r, state_nxt;
  logic [3:0]        num_rounds_r;
  logic [KIDX_W-1:0] nr_eff;
  logic [KIDX_W-1:0] round_r, round_nxt;
  logic [KIDX_W-1:0] rd_addr;
  aes_blk_t          blk_r, blk_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  aes_blk_t          out_blk_r, out_blk_nxt;
  logic              out_last_r, out_last_nxt;
  logic [63:0]       key_hi_r, key_lo_r;
  aes_blk_t          rnd_out;
  logic              in_acc, key_wr, final_rnd;

  logic [63:0] key_hi_mem [0:MAX_ROUNDS];
  logic [63:0] key_lo_mem [0:MAX_ROUNDS];

  always_comb begin
    if (num_rounds_r < NR_MIN) begin
      nr_eff = KIDX_W'(NR_MIN);
    end else if (num_rounds_r > 4'(MAX_ROUNDS)) begin
      nr_eff = LAST_KEY;
    end else begin
      nr_eff = KIDX_W'(num_rounds_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rounds_r <= 4'd10;
    end else if (cfg_we) begin
      num_rounds_r <= cfg_wdata;
    end
  end

  assign in_acc = in_chan.valid && in_chan.ready;
  assign key_wr = in_acc && (in_chan.cmd == CMD_LOAD) &&
                  (in_chan.key_index <= 4'(MAX_ROUNDS));

  // key store, one bank per half
  always_ff @(posedge clk) begin
    if (key_wr) begin
      if (in_chan.key_half == HALF_UPPER) begin
        key_hi_mem[in_chan.key_index[KIDX_W-1:0]] <= in_chan.data_hi;
      end else begin
        key_lo_mem[in_chan.key_index[KIDX_W-1:0]] <= in_chan.data_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_hi_r <= key_hi_mem[rd_addr];
    key_lo_r <= key_lo_mem[rd_addr];
  end

  assign final_rnd = (round_r == nr_eff);
  assign rnd_out   = aes_round(blk_r, {key_hi_r, key_lo_r}, round_r == '0, final_rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    last_r     <= last_nxt;
    out_blk_r  <= out_blk_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    blk_nxt       = blk_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_blk_nxt   = out_blk_r;
    out_last_nxt  = out_last_r;
    rd_addr       = '0;
    in_chan.ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid && (in_chan.cmd == CMD_ENCRYPT)) begin
          blk_nxt   = {in_chan.data_hi, in_chan.data_lo};
          last_nxt  = in_chan.last_block;
          round_nxt = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rd_addr = final_rnd ? round_r : round_r + 1'b1;
        if (!final_rnd) begin
          blk_nxt   = rnd_out;
          round_nxt = round_r + 1'b1;
        end else if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = rnd_out;
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.cipher_hi = out_blk_r[127:64];
  assign out_chan.cipher_lo = out_blk_r[63:0];
  assign out_chan.last_out  = out_last_r;

endmodule

// File: design/aes_enc_chk.sv
// ----------------------------------------------------------------------------
// aes_enc_chk
// port-level checks for the aes block encrypt core, bound to the top level
// ----------------------------------------------------------------------------
`include "aes_block_encrypt_assert.svh"

module aes_enc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_cipher_hi,
  input logic [63:0] out_cipher_lo,
  input logic        out_last
);
  import aes_enc_pkg::*;

  // an encrypt request closes the input once it is accepted
  `AES_ENC_ASSERT_NEXT(a_enc_busy, in_valid && in_ready && (in_cmd == CMD_ENCRYPT), !in_ready)

  // a key load leaves the input open
  `AES_ENC_ASSERT_NEXT(a_load_open, in_valid && in_ready && (in_cmd == CMD_LOAD), in_ready)

  // a result waits until taken
  `AES_ENC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  `AES_ENC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
    $stable(out_cipher_hi) && $stable(out_cipher_lo) && $stable(out_last))

endmodule

bind aes_block_encrypt aes_enc_chk u_aes_enc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_cmd        (in_chan.cmd),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_cipher_hi (out_chan.cipher_hi),
  .out_cipher_lo (out_chan.cipher_lo),
  .out_last      (out_chan.last_out)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for aes_block_encrypt: round keys go in as load requests,
// blocks are encrypted under a set of round count settings, and each ciphertext is
// compared with a known vector or with an aes model kept inside the bench. both
// channels stall at random, and one long output stall backs the core up into its
// request side.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_enc_pkg::*;

  localparam logic HALF_LOWER = ~HALF_UPPER;
  localparam int KEY_SLOTS  = 15;
  localparam int SETTLE     = 24;
  localparam int WDOG_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;
  localparam int PHASE_REQS = 95;

  localparam logic [127:0] FIPS_PT  = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] FIPS_CT  = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
  localparam logic [255:0] FIPS_KEY = {128'h000102030405060708090a0b0c0d0e0f, 128'h0};
  localparam logic [63:0]  ONES     = 64'hffffffffffffffff;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } ct_t;

  typedef struct packed {
    logic         cmd;
    logic [3:0]   kidx;
    logic         khalf;
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic         last;
    logic         known;
    logic [127:0] ct;
  } vec_t;

  vec_t opening_vecs [15] = '{
    '{CMD_ENCRYPT, 4'd0,  HALF_UPPER, FIPS_PT[127:64], FIPS_PT[63:0], 1'b1, 1'b1, FIPS_CT},
    '{CMD_ENCRYPT, 4'd0,  HALF_UPPER, FIPS_PT[127:64], FIPS_PT[63:0], 1'b0, 1'b1, FIPS_CT},
    '{CMD_ENCRYPT, 4'd0,  HALF_UPPER, 64'h0, 64'h0, 1'b0, 1'b0, 128'h0},
    '{CMD_ENCRYPT, 4'd15, HALF_LOWER, ONES, ONES, 1'b1, 1'b0, 128'h0},
    '{CMD_LOAD,    4'd15, HALF_UPPER, ONES, ONES, 1'b1, 1'b0, 128'h0},
    '{CMD_LOAD,    4'd15, HALF_LOWER, ONES, ONES, 1'b0, 1'b0, 128'h0},
    '{CMD_ENCRYPT, 4'd0,  HALF_UPPER, FIPS_PT[127:64], FIPS_PT[63:0], 1'b1, 1'b1, FIPS_CT},
    '{CMD_LOAD,    4'd14, HALF_UPPER, ONES, 64'h0, 1'b0, 1'b0, 128'h0},
    '{CMD_LOAD,    4'd14, HALF_LOWER, 64'h0, ONES, 1'b1, 1'b0, 128'h0},
    '{CMD_ENCRYPT, 4'd0,  HALF_UPPER, FIPS_PT[127:64], FIPS_PT[63:0], 1'b0, 1'b1, FIPS_CT},
    '{CMD_LOAD,    4'd10, HALF_LOWER, ONES, 64'h0, 1'b0, 1'b0, 128'h0},
    '{CMD_ENCRYPT, 4'd0,  HALF_UPPER, ONES, ONES, 1'b0, 1'b0, 128'h0},
    '{CMD_LOAD,    4'd0,  HALF_UPPER, 64'h0, ONES, 1'b0, 1'b0, 128'h0},
    '{CMD_ENCRYPT, 4'd0,  HALF_UPPER, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a,
      1'b1, 1'b0, 128'h0},
    '{CMD_ENCRYPT, 4'd0,  HALF_UPPER, 64'h0, 64'h0, 1'b1, 1'b0, 128'h0}
  };

  logic [3:0] round_plan [7] = '{4'd12, 4'd14, 4'd11, 4'd13, 4'd0, 4'd15, 4'd10};

  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_we;
  logic [3:0]   cfg_wdata;

  logic [7:0]   sbox_tab [256];
  logic [63:0]  key_words [2 * KEY_SLOTS];
  logic [3:0]   rounds_cfg;
  ct_t          pending_ct [$];
  logic         vector_known;
  logic [127:0] vector_ct;
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           rx_hold = 0;
  bit           rx_jitter = 1'b1;
  bit           tx_jitter = 1'b1;
  bit           rx_calm = 1'b0;
  bit           tx_calm = 1'b0;

  aes_enc_in_if  req_ch ();
  aes_enc_out_if ct_ch ();

  aes_block_encrypt dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_ch),
    .out_chan  (ct_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  wire in_fire  = req_ch.valid && req_ch.ready;
  wire out_fire = ct_ch.valid && ct_ch.ready;

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return (a << 1) ^ ({8{a[7]}} & 8'h1b);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // multiplicative inverse followed by the affine map
  function automatic void build_sbox();
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) b = y[7:0];
      end
      sbox_tab[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
  endfunction

  function automatic ct_t aes_cipher(input logic [63:0] hi, input logic [63:0] lo,
                                     input logic last);
    logic [7:0]   st [16];
    logic [7:0]   nx [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] blk;
    logic [127:0] rk;
    int           nr;
    ct_t          res;
    nr = rounds_cfg;
    if (nr < 10) nr = 10;
    if (nr > KEY_SLOTS - 1) nr = KEY_SLOTS - 1;
    blk = {hi, lo};
    for (int i = 0; i < 16; i++) st[i] = blk[127 - 8 * i -: 8];
    for (int r = 0; r <= nr; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++) begin
          for (int row = 0; row < 4; row++) begin
            nx[row + 4 * c] = sbox_tab[st[row + 4 * ((c + row) % 4)]];
          end
        end
        st = nx;
      end
      if (r > 0 && r < nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4 * c];
          a1 = st[4 * c + 1];
          a2 = st[4 * c + 2];
          a3 = st[4 * c + 3];
          st[4 * c]     = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
          st[4 * c + 1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
          st[4 * c + 2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
          st[4 * c + 3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
        end
      end
      rk = {key_words[2 * r], key_words[2 * r + 1]};
      for (int i = 0; i < 16; i++) st[i] ^= rk[127 - 8 * i -: 8];
    end
    for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = st[i];
    res.hi   = blk[127:64];
    res.lo   = blk[63:0];
    res.last = last;
    return res;
  endfunction

  task automatic send_req(input logic cmd, input logic [3:0] kidx, input logic khalf,
                          input logic [63:0] hi, input logic [63:0] lo, input logic last,
                          input logic known, input logic [127:0] ct);
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.key_index  <= kidx;
    req_ch.key_half   <= khalf;
    req_ch.data_hi    <= hi;
    req_ch.data_lo    <= lo;
    req_ch.last_block <= last;
    vector_known      <= known;
    vector_ct         <= ct;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic tx_gap();
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (tx_jitter && !tx_calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_ct.size() != 0) @(posedge clk);
  endtask

  task automatic set_rounds(input logic [3:0] nr);
    req_ch.valid <= 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= nr;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // nk of 0 gives unrelated random round keys instead of an expanded schedule
  task automatic install_keys(input logic [255:0] key, input int nk, input int nrk);
    logic [31:0] w [4 * KEY_SLOTS];
    logic [31:0] t;
    logic [7:0]  rc;
    int          start;
    int          slot;
    rc = 8'h01;
    for (int i = 0; i < 4 * (nrk + 1); i++) begin
      if (i < nk) begin
        w[i] = key[255 - 32 * i -: 32];
      end else if (nk == 0) begin
        w[i] = $urandom;
      end else begin
        t = w[i - 1];
        if (i % nk == 0) begin
          t  = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = gf_dbl(rc);
        end else if (nk > 6 && i % nk == 4) begin
          t = sub_word(t);
        end
        w[i] = w[i - nk] ^ t;
      end
    end
    start = $urandom_range(0, 2 * nrk + 1);
    for (int j = 0; j < 2 * (nrk + 1); j++) begin
      slot = (j + start) % (2 * (nrk + 1));
      tx_gap();
      send_req(CMD_LOAD, 4'(slot / 2), 1'(slot % 2), {w[2 * slot], w[2 * slot + 1]},
               {$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'b0, 128'h0);
    end
  endtask

  always @(posedge clk) begin
    ct_t want;
    ct_t got;
    if (!rst_n) begin
      rounds_cfg = 4'd10;
    end else begin
      if (cfg_we) rounds_cfg = cfg_wdata;
      if (in_fire) begin
        if (req_ch.cmd == CMD_LOAD) begin
          if (req_ch.key_index < KEY_SLOTS)
            key_words[2 * req_ch.key_index + req_ch.key_half] = req_ch.data_hi;
        end else if (vector_known) begin
          pending_ct.push_back({vector_ct, req_ch.last_block});
        end else begin
          pending_ct.push_back(aes_cipher(req_ch.data_hi, req_ch.data_lo, req_ch.last_block));
        end
      end
      if (out_fire) begin
        got = {ct_ch.cipher_hi, ct_ch.cipher_lo, ct_ch.last_out};
        if (pending_ct.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb_top: ciphertext with no request pending: %h_%h last %b",
                     got.hi, got.lo, got.last);
        end else begin
          want = pending_ct.pop_front();
          if (got.hi !== want.hi || got.lo !== want.lo || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tb_top: ciphertext mismatch: expected %h_%h last %b, got %h_%h last %b",
                       want.hi, want.lo, want.last, got.hi, got.lo, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !in_fire && !out_fire) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    ct_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        ct_ch.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else if (rx_jitter && !rx_calm && $urandom_range(0, 5) == 0) begin
        ct_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        ct_ch.ready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(0, 59) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    logic [255:0] seed_key;
    int           pick;
    int           nr;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 4'd0;
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= CMD_LOAD;
    req_ch.key_index  <= 4'd0;
    req_ch.key_half   <= HALF_UPPER;
    req_ch.data_hi    <= 64'h0;
    req_ch.data_lo    <= 64'h0;
    req_ch.last_block <= 1'b0;
    vector_known      <= 1'b0;
    vector_ct         <= 128'h0;
    build_sbox();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_jitter = 1'b0;
    install_keys(FIPS_KEY, 4, 10);
    foreach (opening_vecs[i]) begin
      send_req(opening_vecs[i].cmd, opening_vecs[i].kidx, opening_vecs[i].khalf,
               opening_vecs[i].hi, opening_vecs[i].lo, opening_vecs[i].last,
               opening_vecs[i].known, opening_vecs[i].ct);
    end

    foreach (round_plan[p]) begin
      tx_jitter = (p != $size(round_plan) - 1);
      rx_jitter = tx_jitter;
      set_rounds(round_plan[p]);
      for (int k = 0; k < 8; k++) seed_key[32 * k +: 32] = $urandom;
      nr = round_plan[p];
      case (round_plan[p]) inside
        4'd12:        install_keys(seed_key, 6, 12);
        4'd14, 4'd15: install_keys(seed_key, 8, 14);
        4'd11, 4'd13: install_keys(seed_key, 0, nr);
        default:      install_keys(seed_key, 4, 10);
      endcase
      for (int n = 0; n < PHASE_REQS; n++) begin
        // output side stalls long enough for requests to back up
        if (p == 1 && n == 30) rx_hold = LONG_HOLD;
        if (p == 2 && n == 40) begin
          req_ch.valid <= 1'b0;
          drain();
        end
        tx_gap();
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          send_req(CMD_ENCRYPT, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                   {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                   1'b0, 128'h0);
        end else if (pick < 95) begin
          send_req(CMD_LOAD, 4'($urandom_range(0, KEY_SLOTS - 1)), 1'($urandom_range(0, 1)),
                   {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                   1'b0, 128'h0);
        end else begin
          send_req(CMD_LOAD, 4'd15, 1'($urandom_range(0, 1)),
                   {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                   1'b0, 128'h0);
        end
      end
    end

    req_ch.valid <= 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/aes_enc_pkg.sv
design/aes_enc_in_if.sv
design/aes_enc_out_if.sv
design/aes_block_encrypt.sv
design/aes_enc_chk.sv
dv/tb_top.sv
